/* design/assert_macros.svh */
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a given clock and active-low reset
`define TPP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same, on the block clock and reset
`define TPP_ASSERT(label, prop, msg) \
    `TPP_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

/* design/tpp_pkg.sv */
// shared types, command codes and constants of the turtle plotter
`default_nettype none

package tpp_pkg;

    localparam int DEF_COLUMNS    = 64;
    localparam int DEF_ROWS       = 32;
    localparam int ROW_W          = 64;
    localparam int MAX_PRINT_ROWS = 32;
    localparam int ROW_IDX_W      = 5;
    localparam int OP_W           = 3;
    localparam int DIST_W         = 8;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_PEN_UP     = 3'd0;
    localparam t_op OP_PEN_DOWN   = 3'd1;
    localparam t_op OP_TURN_RIGHT = 3'd2;
    localparam t_op OP_TURN_LEFT  = 3'd3;
    localparam t_op OP_FORWARD    = 3'd4;
    localparam t_op OP_PRINT      = 3'd5;
    localparam t_op OP_QUIT       = 3'd6;
    localparam t_op OP_NONE       = 3'd7;

    typedef logic [1:0] t_head;

    localparam t_head HEAD_NORTH = 2'd0;
    localparam t_head HEAD_EAST  = 2'd1;
    localparam t_head HEAD_SOUTH = 2'd2;
    localparam t_head HEAD_WEST  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic apply_op;
        logic load_steps;
        logic step_read;
        logic step_write;
        logic print_start;
        logic print_read;
        logic print_next;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic halted;
        logic steps_last;
        logic row_last;
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/tpp_if.sv */
// command and row channel interfaces
`default_nettype none

interface tpp_cmd_if;
    logic                   valid;
    logic                   ready;
    logic [2:0]             op;
    logic [7:0]             distance;

    modport source (output valid, output op, output distance, input ready);
    modport sink   (input valid, input op, input distance, output ready);
    modport mon    (input valid, input op, input distance, input ready);
endinterface

interface tpp_row_if;
    logic                   valid;
    logic                   ready;
    logic [63:0]            row_bits;
    logic [4:0]             row_index;
    logic                   last_row;

    modport source (output valid, output row_bits, output row_index, output last_row,
                    input ready);
    modport sink   (input valid, input row_bits, input row_index, input last_row,
                    output ready);
    modport mon    (input valid, input row_bits, input row_index, input last_row,
                    input ready);
endinterface

`default_nettype wire

/* design/turtle_pen_plotter_core.sv */
// Sequencing: pen, turn, quit and none items, and a zero-length forward, finish in the idle state;
//   forward does a canvas row read, then a row write (pen down only), per step on the one canvas memory.
// Print: each row is a registered memory read, then the row is held in the output until
//   taken; min(ROWS, 32) rows per print.
// Reset: synchronous, active low; turtle state returns to origin, facing east, pen down;
//   per-row valid flops make the canvas read as cleared at once, with no clearing pass.
`default_nettype none

module turtle_pen_plotter_core #(
    parameter int COLUMNS = tpp_pkg::DEF_COLUMNS,
    parameter int ROWS    = tpp_pkg::DEF_ROWS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tpp_cmd_if.sink    i_cmd,
    tpp_row_if.source  o_row
);
    import tpp_pkg::*;

    // command and status between the controller and the datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic in_ready;
    logic out_valid;

    // controller: one item at a time, walks forward steps and print rows
    tpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_op        (i_cmd.op),
        .i_distance  (i_cmd.distance),
        .i_out_ready (o_row.ready),
        .i_stat      (dp_stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (dp_cmd)
    );

    // datapath: pen position, heading, flags, canvas and the row being shown
    tpp_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_op        (i_cmd.op),
        .i_distance  (i_cmd.distance),
        .o_stat      (dp_stat),
        .o_row_bits  (o_row.row_bits),
        .o_row_index (o_row.row_index),
        .o_last_row  (o_row.last_row)
    );

    // the row payload comes straight from the read register, which holds while stalled
    assign i_cmd.ready = in_ready;
    assign o_row.valid = out_valid;

endmodule

`default_nettype wire

/* design/tpp_ctrl.sv */
// controller state machine of the turtle plotter
`default_nettype none

module tpp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire tpp_pkg::t_op      i_op,
    input  wire logic [7:0]        i_distance,
    input  wire logic              i_out_ready,
    input  wire tpp_pkg::t_dp_stat i_stat,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output tpp_pkg::t_dp_cmd       o_cmd
);
    import tpp_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_STEP_RD   = 3'd1;
    localparam logic [2:0] S_STEP_WR   = 3'd2;
    localparam logic [2:0] S_PRINT_RD  = 3'd3;
    localparam logic [2:0] S_PRINT_OUT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !i_stat.halted) begin
                    unique case (i_op) inside
                        OP_PEN_UP, OP_PEN_DOWN, OP_TURN_RIGHT, OP_TURN_LEFT, OP_QUIT: begin
                            o_cmd.apply_op = 1'b1;
                        end
                        OP_FORWARD: begin
                            if (i_distance != '0) begin
                                o_cmd.load_steps = 1'b1;
                                n_state          = S_STEP_RD;
                            end
                        end
                        OP_PRINT: begin
                            o_cmd.print_start = 1'b1;
                            n_state           = S_PRINT_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_STEP_RD: begin
                o_cmd.step_read = 1'b1;
                n_state         = S_STEP_WR;
            end
            S_STEP_WR: begin
                o_cmd.step_write = 1'b1;
                n_state          = i_stat.steps_last ? S_IDLE : S_STEP_RD;
            end
            S_PRINT_RD: begin
                o_cmd.print_read = 1'b1;
                n_state          = S_PRINT_OUT;
            end
            S_PRINT_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.print_next = 1'b1;
                    n_state          = i_stat.row_last ? S_IDLE : S_PRINT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* design/tpp_dp.sv */
// datapath: turtle state, canvas memory and print row register
`default_nettype none

module tpp_dp #(
    parameter int COLUMNS = tpp_pkg::DEF_COLUMNS,
    parameter int ROWS    = tpp_pkg::DEF_ROWS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tpp_pkg::t_dp_cmd  i_cmd,
    input  wire tpp_pkg::t_op      i_op,
    input  wire logic [7:0]        i_distance,
    output tpp_pkg::t_dp_stat      o_stat,
    output logic [63:0]            o_row_bits,
    output logic [4:0]             o_row_index,
    output logic                   o_last_row
);
    import tpp_pkg::*;

    localparam int XW = $clog2(COLUMNS);
    localparam int AW = $clog2(ROWS);
    localparam int PRINT_ROWS = (ROWS < MAX_PRINT_ROWS) ? ROWS : MAX_PRINT_ROWS;
    localparam logic [ROW_W-1:0] COL_MASK =
        (COLUMNS >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << COLUMNS) - ROW_W'(1));
    localparam logic [XW-1:0]        X_MAX    = XW'(COLUMNS - 1);
    localparam logic [AW-1:0]        Y_MAX    = AW'(ROWS - 1);
    localparam logic [ROW_IDX_W-1:0] ROW_LAST = ROW_IDX_W'(PRINT_ROWS - 1);

    logic [ROW_W-1:0]     mem [ROWS];
    logic [ROWS-1:0]      r_vld;
    logic [ROW_W-1:0]     r_rd_data;
    logic                 r_rd_vld;

    logic [XW-1:0]        r_x;
    logic [XW-1:0]        n_x;
    logic [AW-1:0]        r_y;
    logic [AW-1:0]        n_y;
    t_head                r_head;
    t_head                n_head;
    logic                 r_pen;
    logic                 n_pen;
    logic                 r_halt;
    logic                 n_halt;
    logic [DIST_W-1:0]    r_steps;
    logic [DIST_W-1:0]    n_steps;
    logic [ROW_IDX_W-1:0] r_row;
    logic [ROW_IDX_W-1:0] n_row;

    logic [AW-1:0]        rd_addr;
    logic [ROW_W-1:0]     eff_row;
    logic                 wr_en;

    assign rd_addr = i_cmd.step_read ? r_y : AW'(r_row);
    // a row never written reads as cleared
    assign eff_row = r_rd_vld ? r_rd_data : '0;
    assign wr_en   = i_cmd.step_write && r_pen;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_y] <= eff_row | (ROW_W'(1) << r_x);
        end
        if (i_cmd.step_read || i_cmd.print_read) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_head  = r_head;
        n_pen   = r_pen;
        n_halt  = r_halt;
        n_steps = r_steps;
        n_row   = r_row;
        if (i_cmd.apply_op) begin
            case (i_op)
                OP_PEN_UP:     n_pen  = 1'b0;
                OP_PEN_DOWN:   n_pen  = 1'b1;
                OP_TURN_RIGHT: n_head = r_head + 2'd1;
                OP_TURN_LEFT:  n_head = r_head - 2'd1;
                OP_QUIT:       n_halt = 1'b1;
                default: begin
                end
            endcase
        end
        if (i_cmd.load_steps) begin
            n_steps = i_distance;
        end
        if (i_cmd.step_write) begin
            n_steps = r_steps - DIST_W'(1);
            // move one cell, holding at the canvas edge
            case (r_head)
                HEAD_NORTH: if (r_y != '0)    n_y = r_y - AW'(1);
                HEAD_SOUTH: if (r_y != Y_MAX) n_y = r_y + AW'(1);
                HEAD_EAST:  if (r_x != X_MAX) n_x = r_x + XW'(1);
                default:    if (r_x != '0)    n_x = r_x - XW'(1);
            endcase
        end
        if (i_cmd.print_start) begin
            n_row = '0;
        end else if (i_cmd.print_next) begin
            n_row = r_row + ROW_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_head   <= HEAD_EAST;
            r_pen    <= 1'b1;
            r_halt   <= 1'b0;
            r_steps  <= '0;
            r_row    <= '0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_head  <= n_head;
            r_pen   <= n_pen;
            r_halt  <= n_halt;
            r_steps <= n_steps;
            r_row   <= n_row;
            if (wr_en) begin
                r_vld[r_y] <= 1'b1;
            end
            if (i_cmd.step_read || i_cmd.print_read) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    assign o_stat.halted     = r_halt;
    assign o_stat.steps_last = (r_steps == DIST_W'(1));
    assign o_stat.row_last   = (r_row == ROW_LAST);

    assign o_row_bits  = eff_row & COL_MASK;
    assign o_row_index = r_row;
    assign o_last_row  = (r_row == ROW_LAST);

endmodule

`default_nettype wire

/* design/tpp_checker.sv */
// port checker of the turtle plotter, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module tpp_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_cmd_ready,
    input wire logic                          i_row_valid,
    input wire logic                          i_row_ready,
    input wire logic [tpp_pkg::ROW_W-1:0]     i_row_bits,
    input wire logic [tpp_pkg::ROW_IDX_W-1:0] i_row_index,
    input wire logic                          i_row_last
);
    import tpp_pkg::*;

    logic                       row_stall;
    logic                       row_take;
    logic [ROW_W+ROW_IDX_W:0]   row_word;

    assign row_stall = i_row_valid && !i_row_ready;
    assign row_take  = i_row_valid && i_row_ready;
    assign row_word  = {i_row_bits, i_row_index, i_row_last};

    // a shown row stays until it is taken
    `TPP_ASSERT(a_row_hold, row_stall |=> i_row_valid, "row item dropped")

    // a stalled row keeps its payload
    `TPP_ASSERT(a_row_stable, row_stall |=> $stable(row_word), "stalled row changed")

    // no command is taken while a print is showing rows
    `TPP_ASSERT(a_no_cmd_in_print, i_row_valid |-> !i_cmd_ready, "command taken during print")

    // the final row returns the block to taking commands
    `TPP_ASSERT(a_last_to_idle, row_take && i_row_last |=> i_cmd_ready && !i_row_valid, "print did not end on last row")

endmodule

bind turtle_pen_plotter_core tpp_checker u_tpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_ready (i_cmd.ready),
    .i_row_valid (o_row.valid),
    .i_row_ready (o_row.ready),
    .i_row_bits  (o_row.row_bits),
    .i_row_index (o_row.row_index),
    .i_row_last  (o_row.last_row)
);

`default_nettype wire

/* dv/turtle_pen_plotter_checker.sv */
// command and row monitor with a canvas predictor and an in-order row comparator
`timescale 1ns / 1ps

module turtle_pen_plotter_checker #(
    parameter int COLUMNS = tpp_pkg::DEF_COLUMNS,
    parameter int ROWS    = tpp_pkg::DEF_ROWS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpp_cmd_if.mon    i_cmd,
    tpp_row_if.mon    i_row,
    output int        o_fail_count,
    output int        o_rows_pending,
    output int        o_rows_checked
);
    import tpp_pkg::*;

    localparam int PRINT_ROWS = (ROWS < MAX_PRINT_ROWS) ? ROWS : MAX_PRINT_ROWS;
    localparam logic [ROW_W-1:0] COL_MASK =
        (COLUMNS >= ROW_W) ? '1 : ((64'd1 << COLUMNS) - 64'd1);

    typedef struct packed {
        logic [ROW_W-1:0]     bits;
        logic [ROW_IDX_W-1:0] index;
        logic                 last;
    } t_row;

    t_row             rows_due_q[$];
    logic [ROW_W-1:0] ink_map [ROWS];
    int               pen_col;
    int               pen_row;
    t_head            facing;
    logic             inking;
    logic             stopped;

    initial begin
        o_fail_count   = 0;
        o_rows_pending = 0;
        o_rows_checked = 0;
    end

    // one unit of forward motion: ink, then move and clamp at the edge
    function automatic void take_stride();
        if (inking) begin
            ink_map[pen_row][pen_col] = 1'b1;
        end
        case (facing)
            HEAD_NORTH: if (pen_row > 0) pen_row--;
            HEAD_SOUTH: if (pen_row + 1 < ROWS) pen_row++;
            HEAD_EAST:  if (pen_col + 1 < COLUMNS) pen_col++;
            default:    if (pen_col > 0) pen_col--;
        endcase
    endfunction

    function automatic void queue_print();
        t_row r;
        for (int i = 0; i < PRINT_ROWS; i++) begin
            r.bits  = ink_map[i] & COL_MASK;
            r.index = ROW_IDX_W'(i);
            r.last  = (i + 1 == PRINT_ROWS);
            rows_due_q.push_back(r);
        end
    endfunction

    function automatic void apply_command(t_op op, logic [DIST_W-1:0] steps);
        if (stopped) begin
            return;
        end
        case (op)
            OP_PEN_UP:     inking = 1'b0;
            OP_PEN_DOWN:   inking = 1'b1;
            OP_TURN_RIGHT: facing = facing + 2'd1;
            OP_TURN_LEFT:  facing = facing + 2'd3;
            OP_FORWARD:    for (int s = 0; s < int'(steps); s++) take_stride();
            OP_PRINT:      queue_print();
            OP_QUIT:       stopped = 1'b1;
            default:       ;
        endcase
    endfunction

    function automatic void compare_row(t_row got);
        t_row want;
        if (rows_due_q.size() == 0) begin
            $display("%0t: unexpected row: index %0d bits %h last %0b",
                     $time, got.index, got.bits, got.last);
            o_fail_count++;
            return;
        end
        want = rows_due_q.pop_front();
        o_rows_checked++;
        if (got.bits !== want.bits) begin
            $display("%0t: row_bits mismatch on row %0d: expected %h actual %h",
                     $time, want.index, want.bits, got.bits);
            o_fail_count++;
        end
        if (got.index !== want.index) begin
            $display("%0t: row_index mismatch: expected %0d actual %0d",
                     $time, want.index, got.index);
            o_fail_count++;
        end
        if (got.last !== want.last) begin
            $display("%0t: last_row mismatch on row %0d: expected %0b actual %0b",
                     $time, want.index, want.last, got.last);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (ink_map[r]) ink_map[r] = '0;
            pen_col = 0;
            pen_row = 0;
            facing  = HEAD_EAST;
            inking  = 1'b1;
            stopped = 1'b0;
            rows_due_q.delete();
        end else begin
            // a row taken at the same edge as a print belongs to an earlier print
            if (i_row.valid && i_row.ready) begin
                compare_row({i_row.row_bits, i_row.row_index, i_row.last_row});
            end
            if (i_cmd.valid && i_cmd.ready) begin
                apply_command(t_op'(i_cmd.op), i_cmd.distance);
            end
        end
        o_rows_pending = rows_due_q.size();
    end

endmodule

/* dv/turtle_pen_plotter_core_test.sv */
// top of the plotter testbench: clock, reset, command stimulus, row back-pressure, verdict
`timescale 1ns / 1ps

module turtle_pen_plotter_core_test;
    import tpp_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int RANDOM_ITEMS    = 92;
    // long receiver hold-off, enough to back the block up into the command channel
    localparam int HOLD_OFF_CYCLES = 300;
    // drain window, longer than the longest forward (distance 255) takes
    localparam int DRAIN_CYCLES    = 600;
    // worst case is far below this: ~120 items of max forward plus stalled prints
    localparam int RUN_LIMIT_NS    = 6_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tpp_cmd_if cmd_ch ();
    tpp_row_if row_ch ();

    int fail_count;
    int rows_pending;
    int rows_checked;

    // handshake between the stimulus and the receiver for the long hold-off
    bit hold_off_req = 1'b0;

    // stimulus bookkeeping for the summary
    int n_items    = 0;
    int n_forward  = 0;
    int n_print    = 0;
    int n_ignored  = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    turtle_pen_plotter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_row   (row_ch)
    );

    turtle_pen_plotter_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_ch),
        .i_row          (row_ch),
        .o_fail_count   (fail_count),
        .o_rows_pending (rows_pending),
        .o_rows_checked (rows_checked)
    );

    // offer one command item after an optional idle gap, hold it until it is taken;
    // returns on the falling edge after the accepting rising edge
    task automatic issue(t_op op, logic [DIST_W-1:0] amount, int gap);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.op       <= op;
        cmd_ch.distance <= amount;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
        n_items++;
        if (op == OP_FORWARD) n_forward++;
        if (op == OP_PRINT) n_print++;
    endtask

    // random command mix: mostly moves and turns so the drawing gets busy,
    // prints often enough to check the canvas many times over
    function automatic t_op pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return OP_PEN_UP;
        if (r < 22) return OP_PEN_DOWN;
        if (r < 34) return OP_TURN_RIGHT;
        if (r < 46) return OP_TURN_LEFT;
        if (r < 80) return OP_FORWARD;
        if (r < 90) return OP_PRINT;
        return OP_NONE;
    endfunction

    // short walks keep the run fast; a few long ones run into the edges
    function automatic logic [DIST_W-1:0] pick_distance(t_op op);
        int r;
        if (op != OP_FORWARD) return DIST_W'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r < 7) return DIST_W'($urandom_range(0, 20));
        if (r < 9) return DIST_W'($urandom_range(21, 80));
        return DIST_W'($urandom_range(0, 255));
    endfunction

    // row receiver: stall pattern switches every so often between free-running,
    // coin-flip and mostly-stalled; one long hold-off when the stimulus asks
    initial begin
        int mode;
        int left_in_mode;
        bit ready_nxt;
        bit hold_done;
        mode = 0;
        left_in_mode = 0;
        hold_done = 1'b0;
        row_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                // block keeps taking commands until its row output backs up
                row_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (left_in_mode == 0) begin
                    mode = $urandom_range(0, 2);
                    left_in_mode = $urandom_range(16, 64);
                end
                left_in_mode--;
                case (mode)
                    0:       ready_nxt = 1'b1;
                    1:       ready_nxt = $urandom_range(0, 1);
                    default: ready_nxt = ($urandom_range(0, 3) == 0);
                endcase
                row_ch.ready <= ready_nxt;
            end
        end
    end

    // command stimulus and verdict
    initial begin
        int burst_left;
        int gap;
        t_op op;
        cmd_ch.valid    = 1'b0;
        cmd_ch.op       = OP_NONE;
        cmd_ch.distance = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: walk into every edge, wrap the heading both ways, move with
        // the pen up, and check the canvas before and after
        issue(OP_FORWARD,    8'd0,   0);   // zero-length move
        issue(OP_FORWARD,    8'd5,   1);   // short stroke along the top row
        issue(OP_PRINT,      8'd255, 0);
        issue(OP_TURN_LEFT,  8'd0,   2);   // east to north
        issue(OP_FORWARD,    8'd3,   0);   // already on the top edge, stays put
        issue(OP_TURN_LEFT,  8'd0,   0);   // north to west wraps the heading
        issue(OP_FORWARD,    8'd255, 3);   // runs into the left edge
        issue(OP_TURN_LEFT,  8'd0,   0);   // west to south
        issue(OP_FORWARD,    8'd255, 0);   // runs into the bottom edge
        issue(OP_TURN_LEFT,  8'd0,   1);   // south to east
        issue(OP_FORWARD,    8'd255, 0);   // runs into the right edge
        issue(OP_TURN_RIGHT, 8'd0,   0);   // east to south
        issue(OP_TURN_RIGHT, 8'd0,   0);   // south to west
        issue(OP_TURN_RIGHT, 8'd0,   2);   // west to north wraps the heading
        issue(OP_FORWARD,    8'd255, 0);   // up the right edge to the top
        issue(OP_PEN_UP,     8'd85,  0);
        issue(OP_TURN_RIGHT, 8'd0,   0);   // north to east, against the edge
        issue(OP_FORWARD,    8'd200, 1);   // pen up and against the edge: moves nothing, inks nothing
        issue(OP_NONE,       8'd255, 0);
        issue(OP_PEN_DOWN,   8'd170, 0);
        issue(OP_TURN_RIGHT, 8'd0,   0);   // east to south
        issue(OP_FORWARD,    8'd7,   0);
        // this print meets the long hold-off, the random items behind it pile up
        hold_off_req = 1'b1;
        issue(OP_PRINT,      8'd0,   0);

        // random: bursts of random length, gaps between them, some back to back
        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gap = 0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            burst_left--;
            op = pick_op();
            issue(op, pick_distance(op), gap);
        end

        // halt, then items that must all be ignored, two prints among them
        issue(OP_QUIT,       DIST_W'($urandom_range(0, 255)), 0);
        issue(OP_PRINT,      8'd0,  0);
        issue(OP_FORWARD,    8'd12, 1);
        issue(OP_PEN_UP,     8'd0,  0);
        issue(OP_PRINT,      8'd3,  2);
        n_ignored = 4;
        cmd_ch.valid <= 1'b0;

        while (rows_pending != 0) @(negedge i_clk);
        // any stray row from the halted block shows up in this window
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run covered %0d command items: %0d forward, %0d print, %0d after halt",
                 n_items, n_forward, n_print, n_ignored);
        $display("%0d canvas rows compared, edges clamped on all four sides",
                 rows_checked);
        if (fail_count == 0 && rows_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #RUN_LIMIT_NS;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
